// ===== hdl/bsg_pkg.sv =====
// Shared types, constants and reset values for the binary sign GEMV block.
package bsg_pkg;

  localparam int ROWS_MAX_DEF      = 16;
  localparam int COLS_MAX_DEF      = 256;
  localparam int OUTLIER_DEPTH_DEF = 64;

  localparam int SAMPLE_W   = 16;
  localparam int SCALE_W    = 16;
  localparam int MSUM_W     = 24;
  localparam int PROD_W     = 48;
  localparam int ROW_IDX_W  = 4;
  localparam int OUT_DATA_W = 56;

  localparam int ROWS_CFG_W = 5;
  localparam int COLS_CFG_W = 9;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 5'd16;
  localparam logic [COLS_CFG_W-1:0] COLS_RST = 9'd256;
  localparam logic [THR_W-1:0]      THR_RST  = 15'h7FFF;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic ACT_WEIGHT = 1'b0;
  localparam logic ACT_VECTOR = 1'b1;

  localparam longint PROD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PROD_MIN = -PROD_MAX - 64'sd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RENORM,
    ST_DIV,
    ST_ROW,
    ST_COL_RD,
    ST_COL_ACC,
    ST_SCALE,
    ST_OUT_RD,
    ST_OUT_SEL,
    ST_OUT_MUL,
    ST_OUT_ADD,
    ST_EMIT
  } state_e;

endpackage

// ===== hdl/binary_sign_gemv_with_outliers.sv =====
// Top level: binary sign matrix-vector product with sparse outlier correction.
//
//  channel  | direction | handshake             | payload
//  s_axis   | in        | s_axis_tvalid/tready  | tdata: sample, tuser: action
//  m_axis   | out       | m_axis_tvalid/tready  | tdata: row_index, product
//           |           |                       | tlast: last_row, tuser: overflow
//  cfg      | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//
// Items are taken while idle. The last column of a weight row starts the serial
// scale divide, and no item is taken until it ends. The last vector item starts
// the product pass: per row it reads each column, then each stored outlier, and
// output stalls can hold it. A config write is followed by a position fixup, one
// step per weight loaded in the current run. Reset leaves the stores undefined.
module binary_sign_gemv_with_outliers #(
  parameter int ROWS_MAX      = bsg_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX      = bsg_pkg::COLS_MAX_DEF,
  parameter int OUTLIER_DEPTH = bsg_pkg::OUTLIER_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bsg_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] sample
  input  logic                             s_axis_tuser,   // [0] action
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bsg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [3:0] row_index, [51:4] product
  output logic                             m_axis_tlast,
  output logic                             m_axis_tuser,   // [0] outlier_overflow
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bsg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bsg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int RIW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int CIW = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int RCW = $clog2(ROWS_MAX + 1);
  localparam int CCW = $clog2(COLS_MAX + 1);
  localparam int SIW = (ROWS_MAX * COLS_MAX > 1) ? $clog2(ROWS_MAX * COLS_MAX) : 1;
  localparam int FW  = $clog2(ROWS_MAX * COLS_MAX + 1);
  localparam int OIW = (OUTLIER_DEPTH > 1) ? $clog2(OUTLIER_DEPTH) : 1;
  localparam int OCW = $clog2(OUTLIER_DEPTH + 1);
  localparam int SW  = bsg_pkg::SAMPLE_W;
  localparam int OW  = RIW + CIW + SW;
  localparam int DW  = SW + 1 + CIW;
  localparam int MW  = bsg_pkg::SCALE_W + 1 + DW;
  localparam int PW  = 2 * SW + 2;
  localparam int AW  = ((MW > bsg_pkg::PROD_W) ? MW : bsg_pkg::PROD_W) + 3;
  localparam logic signed [AW-1:0] PMAX = AW'(bsg_pkg::PROD_MAX);
  localparam logic signed [AW-1:0] PMIN = AW'(bsg_pkg::PROD_MIN);

  bsg_pkg::state_e state_q, state_d;

  logic [bsg_pkg::ROWS_CFG_W-1:0] rows_cfg_q;
  logic [bsg_pkg::COLS_CFG_W-1:0] cols_cfg_q;
  logic [bsg_pkg::THR_W-1:0]      thr_q;
  logic [RCW-1:0]                 rows_u;
  logic [CCW-1:0]                 cols_u;

  logic [RCW-1:0]              wr_q, wr_d;
  logic [CIW-1:0]              wc_q, wc_d;
  logic [FW-1:0]               wp_q, wp_d;
  logic [FW-1:0]               ren_q, ren_d;
  logic [bsg_pkg::MSUM_W-1:0]  msum_q, msum_d;
  logic [OCW-1:0]              tot_q, tot_d;
  logic                        drop_q, drop_d;
  logic [CIW-1:0]              vp_q, vp_d;
  logic [RIW-1:0]              divrow_q, divrow_d;
  logic [RIW-1:0]              crow_q, crow_d;
  logic [CIW-1:0]              col_q, col_d;
  logic [OCW-1:0]              oi_q, oi_d;
  logic signed [DW-1:0]        dot_q, dot_d;
  logic signed [AW-1:0]        acc_q, acc_d;
  logic signed [PW-1:0]        prod_q, prod_d;

  logic                        m_valid_q;
  logic [bsg_pkg::ROW_IDX_W-1:0] m_row_q;
  logic [bsg_pkg::PROD_W-1:0]  m_prod_q;
  logic                        m_last_q;
  logic                        m_ovf_q;

  logic in_fire, cfg_fire, out_load;
  logic sign_we, vec_we, out_we, scale_we, div_start, div_done;
  logic signed [SW-1:0]        smp;
  logic [SW-1:0]               mag;
  logic                        mstart, is_out, row_end, last_wrow;
  logic [bsg_pkg::MSUM_W-1:0]  msum_sum;
  logic [OCW-1:0]              tot_base;
  logic                        drop_base;
  logic [CIW-1:0]              vp_eff;
  logic [RIW-1:0]              sr_row;
  logic [CIW-1:0]              sr_col;
  logic [SIW-1:0]              sign_waddr, sign_raddr;
  logic                        sgn_rd;
  logic [SW-1:0]               vec_rd;
  logic [bsg_pkg::SCALE_W-1:0] scale_rd;
  logic [OW-1:0]               ord;
  logic signed [SW-1:0]        o_w;
  logic [RIW-1:0]              o_row;
  logic [CIW-1:0]              o_col;
  logic                        hit;
  logic signed [bsg_pkg::SCALE_W:0] scale_s, s_term;
  logic signed [SW+1:0]        diff;
  logic [bsg_pkg::MSUM_W-1:0]  quot;
  logic [bsg_pkg::PROD_W-1:0]  sat;

  // register clamps
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_u = RCW'(1);
    end else if (32'(rows_cfg_q) > ROWS_MAX) begin
      rows_u = RCW'(ROWS_MAX);
    end else begin
      rows_u = RCW'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_u = CCW'(1);
    end else if (32'(cols_cfg_q) > COLS_MAX) begin
      cols_u = CCW'(COLS_MAX);
    end else begin
      cols_u = CCW'(cols_cfg_q);
    end
  end

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign cfg_fire = cfg_valid_i & cfg_ready_o;
  assign smp      = $signed(s_axis_tdata);
  assign mag      = smp[SW-1] ? SW'(-smp) : SW'(smp);

  assign mstart    = (wp_q == '0);
  assign msum_sum  = (mstart ? '0 : msum_q) + bsg_pkg::MSUM_W'(mag);
  assign tot_base  = mstart ? '0 : tot_q;
  assign drop_base = mstart ? 1'b0 : drop_q;
  assign is_out    = mag > {1'b0, thr_q};
  assign row_end   = (CCW'(wc_q) == cols_u - CCW'(1));
  assign last_wrow = (wr_q == rows_u - RCW'(1));
  assign vp_eff    = (CCW'(vp_q) >= cols_u) ? '0 : vp_q;

  assign o_w   = $signed(ord[OW-1 -: SW]);
  assign o_row = ord[CIW +: RIW];
  assign o_col = ord[CIW-1:0];

  assign sr_row     = (state_q == bsg_pkg::ST_OUT_SEL) ? o_row : crow_q;
  assign sr_col     = (state_q == bsg_pkg::ST_OUT_SEL) ? o_col : col_q;
  assign sign_raddr = SIW'(32'(sr_row) * COLS_MAX + 32'(sr_col));
  assign sign_waddr = SIW'(32'(wr_q[RIW-1:0]) * COLS_MAX + 32'(wc_q));

  assign scale_s = $signed({1'b0, scale_rd});
  assign s_term  = sgn_rd ? scale_s : -scale_s;
  assign diff    = (SW+2)'(o_w) - (SW+2)'(s_term);
  assign hit     = (o_row == crow_q) && (RCW'(o_row) < rows_u) && (CCW'(o_col) < cols_u);

  always_comb begin
    if (acc_q > PMAX) begin
      sat = PMAX[bsg_pkg::PROD_W-1:0];
    end else if (acc_q < PMIN) begin
      sat = PMIN[bsg_pkg::PROD_W-1:0];
    end else begin
      sat = acc_q[bsg_pkg::PROD_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    wr_d      = wr_q;
    wc_d      = wc_q;
    wp_d      = wp_q;
    ren_d     = ren_q;
    msum_d    = msum_q;
    tot_d     = tot_q;
    drop_d    = drop_q;
    vp_d      = vp_q;
    divrow_d  = divrow_q;
    crow_d    = crow_q;
    col_d     = col_q;
    oi_d      = oi_q;
    dot_d     = dot_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    sign_we   = 1'b0;
    vec_we    = 1'b0;
    out_we    = 1'b0;
    scale_we  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    unique case (state_q)
      bsg_pkg::ST_IDLE: begin
        cfg_ready_o   = 1'b1;
        s_axis_tready = ~cfg_valid_i;
        if (cfg_fire) begin
          state_d = bsg_pkg::ST_RENORM;
          wr_d    = '0;
          wc_d    = '0;
          ren_d   = '0;
        end else if (in_fire) begin
          if (s_axis_tuser == bsg_pkg::ACT_WEIGHT) begin
            sign_we = 1'b1;
            msum_d  = msum_sum;
            tot_d   = tot_base;
            drop_d  = drop_base;
            if (is_out) begin
              if (32'(tot_base) < OUTLIER_DEPTH) begin
                out_we = 1'b1;
                tot_d  = tot_base + OCW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            wp_d = wp_q + FW'(1);
            wc_d = wc_q + CIW'(1);
            if (row_end) begin
              msum_d    = '0;
              div_start = 1'b1;
              divrow_d  = wr_q[RIW-1:0];
              state_d   = bsg_pkg::ST_DIV;
              wc_d      = '0;
              if (last_wrow) begin
                wr_d = '0;
                wp_d = '0;
              end else begin
                wr_d = wr_q + RCW'(1);
              end
            end
          end else begin
            vec_we = 1'b1;
            if (CCW'(vp_eff) == cols_u - CCW'(1)) begin
              vp_d    = '0;
              crow_d  = '0;
              state_d = bsg_pkg::ST_ROW;
            end else begin
              vp_d = vp_eff + CIW'(1);
            end
          end
        end
      end
      bsg_pkg::ST_RENORM: begin
        priority if (wr_q >= rows_u) begin
          wr_d    = '0;
          wc_d    = '0;
          wp_d    = '0;
          state_d = bsg_pkg::ST_IDLE;
        end else if (ren_q == wp_q) begin
          state_d = bsg_pkg::ST_IDLE;
        end else begin
          ren_d = ren_q + FW'(1);
          if (row_end) begin
            wc_d = '0;
            wr_d = wr_q + RCW'(1);
          end else begin
            wc_d = wc_q + CIW'(1);
          end
        end
      end
      bsg_pkg::ST_DIV: begin
        if (div_done) begin
          scale_we = 1'b1;
          state_d  = bsg_pkg::ST_IDLE;
        end
      end
      bsg_pkg::ST_ROW: begin
        dot_d   = '0;
        col_d   = '0;
        state_d = bsg_pkg::ST_COL_RD;
      end
      bsg_pkg::ST_COL_RD: begin
        state_d = bsg_pkg::ST_COL_ACC;
      end
      bsg_pkg::ST_COL_ACC: begin
        dot_d = sgn_rd ? dot_q + DW'($signed(vec_rd)) : dot_q - DW'($signed(vec_rd));
        if (CCW'(col_q) == cols_u - CCW'(1)) begin
          state_d = bsg_pkg::ST_SCALE;
        end else begin
          col_d   = col_q + CIW'(1);
          state_d = bsg_pkg::ST_COL_RD;
        end
      end
      bsg_pkg::ST_SCALE: begin
        acc_d   = AW'(scale_s * dot_q);
        oi_d    = '0;
        state_d = (tot_q == '0) ? bsg_pkg::ST_EMIT : bsg_pkg::ST_OUT_RD;
      end
      bsg_pkg::ST_OUT_RD: begin
        state_d = bsg_pkg::ST_OUT_SEL;
      end
      bsg_pkg::ST_OUT_SEL: begin
        state_d = bsg_pkg::ST_OUT_MUL;
      end
      bsg_pkg::ST_OUT_MUL: begin
        prod_d  = hit ? PW'(diff * $signed(vec_rd)) : '0;
        state_d = bsg_pkg::ST_OUT_ADD;
      end
      bsg_pkg::ST_OUT_ADD: begin
        acc_d = acc_q + AW'(prod_q);
        oi_d  = oi_q + OCW'(1);
        state_d = (oi_q + OCW'(1) == tot_q) ? bsg_pkg::ST_EMIT : bsg_pkg::ST_OUT_RD;
      end
      bsg_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          if (RCW'(crow_q) == rows_u - RCW'(1)) begin
            state_d = bsg_pkg::ST_IDLE;
          end else begin
            crow_d  = crow_q + RIW'(1);
            state_d = bsg_pkg::ST_ROW;
          end
        end
      end
      default: state_d = bsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bsg_pkg::ST_IDLE;
      rows_cfg_q <= bsg_pkg::ROWS_RST;
      cols_cfg_q <= bsg_pkg::COLS_RST;
      thr_q      <= bsg_pkg::THR_RST;
      wr_q       <= '0;
      wc_q       <= '0;
      wp_q       <= '0;
      ren_q      <= '0;
      msum_q     <= '0;
      tot_q      <= '0;
      drop_q     <= 1'b0;
      vp_q       <= '0;
      crow_q     <= '0;
      col_q      <= '0;
      oi_q       <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      wc_q    <= wc_d;
      wp_q    <= wp_d;
      ren_q   <= ren_d;
      msum_q  <= msum_d;
      tot_q   <= tot_d;
      drop_q  <= drop_d;
      vp_q    <= vp_d;
      crow_q  <= crow_d;
      col_q   <= col_d;
      oi_q    <= oi_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          bsg_pkg::CFG_NUM_ROWS:  rows_cfg_q <= cfg_data_i[bsg_pkg::ROWS_CFG_W-1:0];
          bsg_pkg::CFG_NUM_COLS:  cols_cfg_q <= cfg_data_i[bsg_pkg::COLS_CFG_W-1:0];
          bsg_pkg::CFG_THRESHOLD: thr_q      <= cfg_data_i[bsg_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    divrow_q <= divrow_d;
    dot_q    <= dot_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    if (out_load) begin
      m_row_q  <= bsg_pkg::ROW_IDX_W'(crow_q);
      m_prod_q <= sat;
      m_last_q <= (RCW'(crow_q) == rows_u - RCW'(1));
      m_ovf_q  <= drop_q;
    end
  end

  bsg_ram #(.DEPTH(ROWS_MAX * COLS_MAX), .WIDTH(1)) u_sign_ram (
    .clk_i   (clk_i),
    .we_i    (sign_we),
    .waddr_i (sign_waddr),
    .wdata_i (~smp[SW-1]),
    .raddr_i (sign_raddr),
    .rdata_o (sgn_rd)
  );

  bsg_ram #(.DEPTH(COLS_MAX), .WIDTH(SW)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vp_eff),
    .wdata_i (s_axis_tdata),
    .raddr_i (sr_col),
    .rdata_o (vec_rd)
  );

  bsg_ram #(.DEPTH(ROWS_MAX), .WIDTH(bsg_pkg::SCALE_W)) u_scale_ram (
    .clk_i   (clk_i),
    .we_i    (scale_we),
    .waddr_i (divrow_q),
    .wdata_i (quot[bsg_pkg::SCALE_W-1:0]),
    .raddr_i (crow_q),
    .rdata_o (scale_rd)
  );

  bsg_ram #(.DEPTH(OUTLIER_DEPTH), .WIDTH(OW)) u_outlier_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (tot_base[OIW-1:0]),
    .wdata_i ({s_axis_tdata, wr_q[RIW-1:0], wc_q}),
    .raddr_i (oi_q[OIW-1:0]),
    .rdata_o (ord)
  );

  bsg_div #(.DIV_W(CCW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (msum_sum),
    .divisor_i  (cols_u),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(bsg_pkg::OUT_DATA_W - bsg_pkg::PROD_W - bsg_pkg::ROW_IDX_W){1'b0}},
                          m_prod_q, m_row_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_ovf_q;

  a_idle_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsg_pkg::ST_IDLE) |-> ((CCW'(wc_q) < cols_u) && (wr_q < rows_u)))
    else $error("weight position out of range while idle");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == bsg_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_last_row_ends_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (RCW'(crow_q) == rows_u - RCW'(1))) |=> (state_q == bsg_pkg::ST_IDLE))
    else $error("product pass did not end after the last row");

  a_outlier_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_we |=> (32'(tot_q) <= OUTLIER_DEPTH))
    else $error("outlier count beyond store depth");

endmodule

// ===== hdl/bsg_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module bsg_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bsg_div.sv =====
// Restoring divider, one quotient bit per cycle, for the row scale.
module bsg_div #(
  parameter int DIV_W = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bsg_pkg::MSUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [bsg_pkg::MSUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(bsg_pkg::MSUM_W + 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [DIV_W:0]             rem_q, rem_d;
  logic [bsg_pkg::MSUM_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0]           dvs_q, dvs_d;
  logic [DIV_W:0]             rem_sh;
  logic                       ge;

  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[bsg_pkg::MSUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(bsg_pkg::MSUM_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[bsg_pkg::MSUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
